@@ hw/rtl/kre_pkg.sv @@
// shared constants and types of the keyboard report to key events block
package kre_pkg;

	// field widths
	localparam int KEY_W      = 8;
	localparam int MOD_W      = 8;
	localparam int S_DATA_W   = 56;
	localparam int M_DATA_W   = 32;

	// slots carried by one input report, and default slot count
	localparam int INPUT_SLOTS   = 6;
	localparam int KEY_SLOTS_DEF = 6;

	// special usages
	localparam logic [KEY_W-1:0] ROLLOVER_CODE  = 8'h01;
	localparam logic [KEY_W-1:0] CAPS_LOCK_CODE = 8'h39;

	// request kinds on the input side
	localparam logic FUNC_REPORT = 1'b0;
	localparam logic FUNC_RESET  = 1'b1;

	// event kinds on the output side
	localparam logic EVENT_RELEASE = 1'b0;
	localparam logic EVENT_PRESS   = 1'b1;

	// modifiers that travel with every event of one report
	typedef struct packed {
		logic [MOD_W-1:0] report_mods;
		logic [MOD_W-1:0] prev_mods;
	} kre_mods_t;

endpackage

@@ hw/rtl/kre_diff.sv @@
// compare of a new report against the held key slots, giving the event list
module kre_diff #(
	parameter int KEY_SLOTS = kre_pkg::KEY_SLOTS_DEF
) (
	input  logic                    func,
	input  logic [kre_pkg::KEY_W-1:0] in_keys   [kre_pkg::INPUT_SLOTS],
	input  logic [kre_pkg::KEY_W-1:0] old_keys  [KEY_SLOTS],
	input  logic                    caps_in,
	output logic [kre_pkg::KEY_W-1:0] next_keys [KEY_SLOTS],
	output logic                    next_caps,
	output logic [2*KEY_SLOTS-1:0]  ev_mask,
	output logic [kre_pkg::KEY_W-1:0] ev_key    [2*KEY_SLOTS],
	output logic [2*KEY_SLOTS-1:0]  ev_caps
);

	logic [kre_pkg::KEY_W-1:0] nk [KEY_SLOTS];
	logic                      rollover;
	logic                      active;

	// slots beyond the input fields read as empty
	for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_slot
		if (g < kre_pkg::INPUT_SLOTS) begin : g_in
			assign nk[g] = in_keys[g];
		end else begin : g_zero
			assign nk[g] = '0;
		end
	end

	// rollover detect and events enabled only for a plain report
	always_comb begin
		rollover = 1'b0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			if (nk[i] == kre_pkg::ROLLOVER_CODE) rollover = 1'b1;
		end
		active = (func == kre_pkg::FUNC_REPORT) && !rollover;
	end

	// release and press candidates, caps lock toggles in press order
	always_comb begin
		logic found;
		logic acc;
		acc = caps_in;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			found = 1'b0;
			for (int j = 0; j < KEY_SLOTS; j++) begin
				if (nk[j] == old_keys[i]) found = 1'b1;
			end
			ev_mask[i] = active && (old_keys[i] != '0) && !found;
			ev_key[i]  = old_keys[i];
			ev_caps[i] = caps_in;
		end
		for (int i = 0; i < KEY_SLOTS; i++) begin
			found = 1'b0;
			for (int j = 0; j < KEY_SLOTS; j++) begin
				if (old_keys[j] == nk[i]) found = 1'b1;
			end
			ev_mask[KEY_SLOTS+i] = active && (nk[i] != '0) && !found;
			if (ev_mask[KEY_SLOTS+i] && (nk[i] == kre_pkg::CAPS_LOCK_CODE)) acc = ~acc;
			ev_key[KEY_SLOTS+i]  = nk[i];
			ev_caps[KEY_SLOTS+i] = acc;
		end
		next_caps = acc;
	end

	// held slots after this request
	always_comb begin
		for (int i = 0; i < KEY_SLOTS; i++) begin
			next_keys[i] = active ? nk[i] : '0;
		end
	end

endmodule

@@ hw/rtl/kre_emit.sv @@
// event buffer that issues one event per unstalled cycle to an output register
module kre_emit #(
	parameter int KEY_SLOTS = kre_pkg::KEY_SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic [2*KEY_SLOTS-1:0]     ev_mask,
	input  logic [kre_pkg::KEY_W-1:0]  ev_key [2*KEY_SLOTS],
	input  logic [2*KEY_SLOTS-1:0]     ev_caps,
	input  kre_pkg::kre_mods_t         mods,
	output logic                       free,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [kre_pkg::M_DATA_W-1:0] m_tdata,
	output logic [0:0]                 m_tuser,
	output logic                       m_tlast
);

	localparam int EV_N = 2 * KEY_SLOTS;

	logic [EV_N-1:0]              mask_s1;
	logic [kre_pkg::KEY_W-1:0]    key_s1 [EV_N];
	logic [EV_N-1:0]              caps_s1;
	kre_pkg::kre_mods_t           mods_s1;

	logic                         m_valid_q;
	logic [kre_pkg::KEY_W-1:0]    key_q;
	logic                         kind_q;
	logic [kre_pkg::MOD_W-1:0]    rep_mods_q;
	logic [kre_pkg::MOD_W-1:0]    tr_mods_q;
	logic                         caps_q;
	logic                         last_q;

	logic                         pend;
	logic                         adv;
	logic [EV_N-1:0]              sel;
	logic                         last;
	logic [kre_pkg::KEY_W-1:0]    sel_key;
	logic                         sel_caps;
	logic                         sel_kind;

	// lowest pending event goes next: releases first, then presses
	always_comb begin
		pend = |mask_s1;
		sel  = mask_s1 & (~mask_s1 + EV_N'(1));
		last = (mask_s1 & ~sel) == '0;
		adv  = pend && (!m_valid_q || m_tready);
		free = !pend || (adv && last);
	end

	// one-hot pick of the chosen event
	always_comb begin
		sel_key  = '0;
		sel_caps = 1'b0;
		sel_kind = kre_pkg::EVENT_RELEASE;
		for (int i = 0; i < EV_N; i++) begin
			if (sel[i]) begin
				sel_key  = sel_key | key_s1[i];
				sel_caps = sel_caps | caps_s1[i];
				if (i >= KEY_SLOTS) sel_kind = kre_pkg::EVENT_PRESS;
			end
		end
	end

	// pending event mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_s1 <= '0;
		end else if (load) begin
			mask_s1 <= ev_mask;
		end else if (adv) begin
			mask_s1 <= mask_s1 & ~sel;
		end
	end

	// event payload of the buffered report
	always_ff @(posedge clk) begin
		if (load) begin
			key_s1  <= ev_key;
			caps_s1 <= ev_caps;
			mods_s1 <= mods;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (adv) begin
			key_q      <= sel_key;
			kind_q     <= sel_kind;
			rep_mods_q <= mods_s1.report_mods;
			tr_mods_q  <= (sel_kind == kre_pkg::EVENT_PRESS) ? mods_s1.report_mods
			                                                 : mods_s1.prev_mods;
			caps_q     <= sel_caps;
			last_q     <= last;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = {7'b0, caps_q, tr_mods_q, rep_mods_q, key_q};
	assign m_tuser[0] = kind_q;
	assign m_tlast    = last_q;

	// a new report enters only once the buffer is empty or draining its last event
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!pend || (adv && last)))
		else $error("report loaded over pending events");

	// the pending mask only loses bits between loads
	a_mask_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		!load |=> (mask_s1 & ~$past(mask_s1)) == '0)
		else $error("event mask gained bits without a load");

	// an issued event shows on the output with its end marker
	a_issue: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (m_tvalid && (m_tlast == $past(last))))
		else $error("issued event not presented");

endmodule

@@ hw/rtl/keyboard_report_to_key_events.sv @@
// top level: held key state, report compare and event output
//
// Takes one request per accepted input beat: a keyboard report (tuser = 0) or a
// reset on connection change (tuser = 1). The report is compared against the
// held key slots in the cycle it is accepted, the held slots, modifiers and caps
// lock flag are updated at once, and the resulting events (releases in old slot
// order, then presses in new slot order) leave one per cycle through an output
// register while the output is not stalled. The event buffer holds the events
// of one report; the next report is taken in the same cycle the last event of
// the previous one moves to the output register. Reset requests, rollover
// reports and reports without changes give no events.
module keyboard_report_to_key_events #(
	parameter int KEY_SLOTS = kre_pkg::KEY_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// modifiers, key_slot_0 .. key_slot_5 from the lowest bit up
	input  logic [kre_pkg::S_DATA_W-1:0]  s_tdata,
	// func
	input  logic [0:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// keycode, report_modifiers, translate_modifiers, caps_state, zero fill
	output logic [kre_pkg::M_DATA_W-1:0]  m_tdata,
	// event_kind
	output logic [0:0]                    m_tuser,
	// last_event
	output logic                          m_tlast
);

	localparam int EV_N = 2 * KEY_SLOTS;

	logic [kre_pkg::KEY_W-1:0] in_keys    [kre_pkg::INPUT_SLOTS];
	logic [kre_pkg::MOD_W-1:0] in_mods;
	logic [kre_pkg::KEY_W-1:0] old_keys_q [KEY_SLOTS];
	logic [kre_pkg::MOD_W-1:0] old_mods_q;
	logic                      caps_lock_q;
	logic [kre_pkg::KEY_W-1:0] next_keys  [KEY_SLOTS];
	logic                      next_caps;
	logic [EV_N-1:0]           ev_mask;
	logic [kre_pkg::KEY_W-1:0] ev_key     [EV_N];
	logic [EV_N-1:0]           ev_caps;
	kre_pkg::kre_mods_t        mods;
	logic                      free;
	logic                      accept;

	// unpack the request
	assign in_mods = s_tdata[kre_pkg::MOD_W-1:0];
	for (genvar g = 0; g < kre_pkg::INPUT_SLOTS; g++) begin : g_unpack
		assign in_keys[g] = s_tdata[kre_pkg::MOD_W + g*kre_pkg::KEY_W +: kre_pkg::KEY_W];
	end

	assign s_tready = free;
	assign accept   = s_tvalid && s_tready;

	assign mods.report_mods = in_mods;
	assign mods.prev_mods   = old_mods_q;

	kre_diff #(
		.KEY_SLOTS (KEY_SLOTS)
	) u_diff (
		.func      (s_tuser[0]),
		.in_keys   (in_keys),
		.old_keys  (old_keys_q),
		.caps_in   (caps_lock_q),
		.next_keys (next_keys),
		.next_caps (next_caps),
		.ev_mask   (ev_mask),
		.ev_key    (ev_key),
		.ev_caps   (ev_caps)
	);

	// held key slots, modifiers and caps lock
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_SLOTS; i++) old_keys_q[i] <= '0;
			old_mods_q  <= '0;
			caps_lock_q <= 1'b0;
		end else if (accept) begin
			old_keys_q  <= next_keys;
			old_mods_q  <= (s_tuser[0] == kre_pkg::FUNC_RESET) ? '0 : in_mods;
			caps_lock_q <= next_caps;
		end
	end

	kre_emit #(
		.KEY_SLOTS (KEY_SLOTS)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.ev_mask  (ev_mask),
		.ev_key   (ev_key),
		.ev_caps  (ev_caps),
		.mods     (mods),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
